FILE: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the system tick timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int TIMER_SLOTS = 8;
   localparam int SLOT_IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int SLOT_CMP_W  = 6;
   localparam int MASK_W      = 8;
   localparam int WORD_W      = 32;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 112;
   localparam int CSR_IDX_W   = 1;

   localparam logic [WORD_W-1:0] TICKS_PER_SECOND_RST = 32'd1000000;
   localparam logic [WORD_W-1:0] TICKS_PER_STEP_RST   = 32'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_STEP   = 1'b1;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_ARM    = 2'd1,
      ACT_DISARM = 2'd2,
      ACT_ACK    = 2'd3
   } action_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic frac;
      logic scan;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// sequencer: capture, execute, remainder fix-up, slot scan, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  stt_pkg::status_type status,
   output stt_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FRAC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.is_tick ? ST_FRAC : ST_DONE;
         end
         ST_FRAC: begin
            cmd.frac = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// counters, slot store, scan compare/advance, config and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module stt_dp (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [stt_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                 csr_wen,
   input  wire  [stt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [stt_pkg::WORD_W-1:0]          csr_wdata,
   input  stt_pkg::cmd_type                    cmd,
   output stt_pkg::status_type                 status,
   output logic [stt_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int N  = stt_pkg::TIMER_SLOTS;
   localparam int SW = stt_pkg::SLOT_IDX_W;
   localparam int W  = stt_pkg::WORD_W;
   localparam logic [SW-1:0] SLOT_LAST = SW'(N - 1);

   stt_pkg::action_type action_ff;
   logic [2:0]          slot_ff;
   logic [W-1:0]        period_ff;

   logic [W-1:0]        tps_ff, tpstep_ff;
   logic [W-1:0]        tick_ff, sec_ff, frac_ff;
   logic [W:0]          frac_sum_ff;

   logic [N-1:0]        active_ff, elapsed_ff, fired_ff;
   logic [W-1:0]        deadline_ff [N];
   logic [W-1:0]        slot_period_ff [N];
   logic [SW-1:0]       scan_idx_ff;

   logic [stt_pkg::RSP_DATA_W-1:0] out_ff;

   logic [stt_pkg::SLOT_CMP_W-1:0] slot_ext;
   logic                           slot_ok;
   logic [SW-1:0]                  slot_idx;
   logic [W+1:0]                   frac_diff;
   logic                           frac_ge;
   logic [W:0]                     frac_res;
   logic                           hit;
   logic [stt_pkg::MASK_W-1:0]     fired_mask, elapsed_mask;

   assign slot_ext  = stt_pkg::SLOT_CMP_W'(slot_ff);
   assign slot_ok   = (slot_ext < stt_pkg::SLOT_CMP_W'(N));
   assign slot_idx  = SW'(slot_ext);
   assign frac_diff = {1'b0, frac_sum_ff} - {2'b00, tps_ff};
   assign frac_ge   = !frac_diff[W+1];
   assign frac_res  = frac_ge ? frac_diff[W:0] : frac_sum_ff;
   assign hit       = active_ff[scan_idx_ff] && (tick_ff >= deadline_ff[scan_idx_ff]);

   assign status.is_tick   = (action_ff == stt_pkg::ACT_TICK);
   assign status.scan_last = (scan_idx_ff == SLOT_LAST);

   for (genvar k = 0; k < stt_pkg::MASK_W; k++) begin : g_mask
      if (k < N) begin : g_slot
         assign fired_mask[k]   = fired_ff[k];
         assign elapsed_mask[k] = elapsed_ff[k];
      end else begin : g_none
         assign fired_mask[k]   = 1'b0;
         assign elapsed_mask[k] = 1'b0;
      end
   end

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff     <= stt_pkg::TICKS_PER_SECOND_RST;
         tpstep_ff  <= stt_pkg::TICKS_PER_STEP_RST;
         tick_ff    <= '0;
         sec_ff     <= '0;
         frac_ff    <= '0;
         active_ff  <= '0;
         elapsed_ff <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               stt_pkg::CSR_TICKS_PER_SECOND: tps_ff    <= csr_wdata;
               stt_pkg::CSR_TICKS_PER_STEP:   tpstep_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            if (action_ff == stt_pkg::ACT_TICK) begin
               tick_ff <= tick_ff + 1'b1;
            end else if (slot_ok) begin
               elapsed_ff[slot_idx] <= 1'b0;
               if (action_ff == stt_pkg::ACT_ARM) begin
                  active_ff[slot_idx] <= 1'b1;
               end else if (action_ff == stt_pkg::ACT_DISARM) begin
                  active_ff[slot_idx] <= 1'b0;
               end
            end
         end
         if (cmd.frac) begin
            sec_ff  <= sec_ff + W'(frac_ge);
            frac_ff <= frac_res[W] ? '1 : frac_res[W-1:0];
         end
         if (cmd.scan && hit) begin
            elapsed_ff[scan_idx_ff] <= 1'b1;
         end
      end
   end

   // item, slot store and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= stt_pkg::action_type'(req_tdata[1:0]);
         slot_ff   <= req_tdata[4:2];
         period_ff <= req_tdata[36:5];
      end
      if (cmd.exec) begin
         fired_ff    <= '0;
         frac_sum_ff <= {1'b0, frac_ff} + {1'b0, tpstep_ff};
         if (action_ff == stt_pkg::ACT_ARM && slot_ok) begin
            slot_period_ff[slot_idx] <= period_ff;
            deadline_ff[slot_idx]    <= tick_ff + period_ff;
         end
      end
      if (cmd.frac) begin
         scan_idx_ff <= '0;
      end
      if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         if (hit) begin
            deadline_ff[scan_idx_ff] <= deadline_ff[scan_idx_ff]
                                        + slot_period_ff[scan_idx_ff];
            fired_ff[scan_idx_ff]    <= 1'b1;
         end
      end
      if (cmd.load_out) begin
         out_ff <= {elapsed_mask,
                    status.is_tick ? fired_mask : {stt_pkg::MASK_W{1'b0}},
                    frac_ff, sec_ff, tick_ff};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

`default_nettype wire

FILE: rtl/system_tick_timer_bank_top.sv
// ----------------------------------------------------------------------------
// system_tick_timer_bank_top
// tick counter with seconds remainder and a bank of periodic timer slots
// ----------------------------------------------------------------------------
// channel   direction  transfer condition          contents
// req_      in         req_tvalid & req_tready     action, slot, period
// rsp_      out        rsp_tvalid & rsp_tready     counts, remainder, masks
// csr_      in         csr_wen                     ticks_per_second/step
//
// a tick runs capture, execute, remainder fix-up, slot scan and hand-off; the slot scan
// visits one slot per cycle through a single compare/advance unit.
// arm, disarm and acknowledge skip the remainder fix-up and the slot scan.
// reset is synchronous; after it all slots are idle and counters are zero.
// a held result in the output register blocks only the hand-off step.
// ----------------------------------------------------------------------------
`default_nettype none

module system_tick_timer_bank_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // action[1:0], slot[4:2], period[36:5], zero fill
   input  wire  [stt_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // tick_count, second_count, second_remainder, fired_mask, elapsed_mask
   output logic [stt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire                                 csr_wen,
   input  wire  [stt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [stt_pkg::WORD_W-1:0]          csr_wdata
);

   stt_pkg::cmd_type    cmd;
   stt_pkg::status_type status;

   stt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
